// ===== src/assert_macros.svh =====
// assertion helpers used by the checker file i2rs_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while rst is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, held off while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/i2rs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2rs_pkg
// shared types, constants and helpers of the radix symbol converter
// ----------------------------------------------------------------------------
package i2rs_pkg;

   localparam int VALUE_W      = 32;
   localparam int SYMBOL_W     = 8;
   localparam int RADIX_W      = 5;
   localparam int SYMS_W       = 64;
   localparam int MAX_RADIX    = 16;
   localparam int SYMBOL_SLOTS = 16;
   localparam int DIGIT_SLOTS  = 32;
   localparam int DIGIT_W      = 4;
   localparam int DIGIT_IDX_W  = $clog2(DIGIT_SLOTS);
   localparam int DIGIT_CNT_W  = DIGIT_IDX_W + 1;
   localparam int CSR_IDX_W    = 2;

   // divider: quotient bits resolved per cycle
   localparam int DIV_BITS  = 8;
   localparam int DIV_STEPS = VALUE_W / DIV_BITS;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [SYMBOL_W-1:0] MINUS_BYTE = 8'h2D;
   localparam logic [SYMBOL_W-1:0] PLUS_BYTE  = 8'h2B;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYM_LOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYM_HI  = 2'd2;

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_first;
      logic div_last;
      logic put_sign;
      logic put_digit;
   } cmd_type;

   typedef struct packed {
      logic base_ok;
      logic neg;
      logic more;
      logic out_free;
      logic last_digit;
   } status_type;

   function automatic logic [SYMBOL_W-1:0] symbol_at(
      input logic [2*SYMS_W-1:0] syms,
      input logic [DIGIT_W-1:0]  d
   );
      symbol_at = syms[d*SYMBOL_W +: SYMBOL_W];
   endfunction

   function automatic logic base_valid(
      input logic [RADIX_W-1:0]  radix,
      input logic [2*SYMS_W-1:0] syms
   );
      logic ok;
      logic [SYMBOL_W-1:0] si;
      ok = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX))
           && (radix <= RADIX_W'(SYMBOL_SLOTS));
      for (int i = 0; i < SYMBOL_SLOTS; i++) begin
         si = syms[i*SYMBOL_W +: SYMBOL_W];
         if (RADIX_W'(i) < radix) begin
            if (si == MINUS_BYTE || si == PLUS_BYTE) ok = 1'b0;
            for (int j = i + 1; j < SYMBOL_SLOTS; j++) begin
               if (RADIX_W'(j) < radix && syms[j*SYMBOL_W +: SYMBOL_W] == si)
                  ok = 1'b0;
            end
         end
      end
      base_valid = ok;
   endfunction

endpackage

// ===== src/i2rs_dp.sv =====
// ----------------------------------------------------------------------------
// i2rs_dp
// datapath: config registers, digit divider, digit store and output word
// ----------------------------------------------------------------------------
module i2rs_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  i2rs_pkg::cmd_type              cmd,
   output i2rs_pkg::status_type           status,
   input  logic                           csr_valid,
   input  logic [i2rs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [i2rs_pkg::SYMS_W-1:0]    csr_wdata,
   input  logic [i2rs_pkg::VALUE_W-1:0]   req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [i2rs_pkg::SYMBOL_W-1:0]  rsp_symbol,
   output logic                           rsp_last
);
   import i2rs_pkg::*;

   logic [RADIX_W-1:0]     radix_ff;
   logic [SYMS_W-1:0]      sym_low_ff, sym_high_ff;
   logic [VALUE_W-1:0]     mag_ff, mag_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic                   neg_ff;
   logic [DIGIT_CNT_W-1:0] nd_ff;
   logic [DIGIT_CNT_W-1:0] nd_dec;
   logic [DIGIT_W-1:0]     digit_ff [DIGIT_SLOTS];
   logic [DIV_BITS-1:0]    qbits;
   logic [DIGIT_W:0]       trial;
   logic [2*SYMS_W-1:0]    syms;
   logic                   rsp_valid_ff;
   logic [SYMBOL_W-1:0]    rsp_symbol_ff;
   logic                   rsp_last_ff;
   logic                   out_free;

   assign syms     = {sym_high_ff, sym_low_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign nd_dec   = nd_ff - DIGIT_CNT_W'(1);

   // restoring division, DIV_BITS quotient bits per cycle
   always_comb begin
      rem_in = cmd.div_first ? '0 : rem_ff;
      qbits  = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {rem_in, mag_ff[VALUE_W-1-k]};
         if (trial >= radix_ff) begin
            trial = trial - radix_ff;
            qbits[DIV_BITS-1-k] = 1'b1;
         end
         rem_in = trial[DIGIT_W-1:0];
      end
      mag_in = {mag_ff[VALUE_W-DIV_BITS-1:0], qbits};
   end

   always_comb begin
      status.base_ok    = base_valid(radix_ff, syms);
      status.neg        = neg_ff;
      status.more       = (mag_in != '0) && (nd_ff < DIGIT_CNT_W'(DIGIT_SLOTS - 1));
      status.out_free   = out_free;
      status.last_digit = (nd_ff == DIGIT_CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= '0;
         sym_low_ff  <= '0;
         sym_high_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIX:   radix_ff    <= csr_wdata[RADIX_W-1:0];
            CSR_SYM_LOW: sym_low_ff  <= csr_wdata;
            CSR_SYM_HI:  sym_high_ff <= csr_wdata;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= req_value[VALUE_W-1];
         mag_ff <= req_value[VALUE_W-1] ? (VALUE_W'(0) - req_value) : req_value;
         nd_ff  <= '0;
      end else if (cmd.div_step) begin
         mag_ff <= mag_in;
         rem_ff <= rem_in;
         if (cmd.div_last) begin
            digit_ff[nd_ff[DIGIT_IDX_W-1:0]] <= rem_in;
            nd_ff <= nd_ff + DIGIT_CNT_W'(1);
         end
      end else if (cmd.put_digit) begin
         nd_ff <= nd_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.put_sign || cmd.put_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put_sign) begin
         rsp_symbol_ff <= MINUS_BYTE;
         rsp_last_ff   <= 1'b0;
      end else if (cmd.put_digit) begin
         rsp_symbol_ff <= symbol_at(syms, digit_ff[nd_dec[DIGIT_IDX_W-1:0]]);
         rsp_last_ff   <= (nd_ff == DIGIT_CNT_W'(1));
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== src/i2rs_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2rs_ctrl
// sequencer: accept, base check, digit divisions, sign and digit output
// ----------------------------------------------------------------------------
module i2rs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  i2rs_pkg::status_type status,
   output i2rs_pkg::cmd_type    cmd
);
   import i2rs_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_in  = '0;
            state_in = status.base_ok ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (step_ff == '0);
            cmd.div_last  = (step_ff == STEP_W'(DIV_STEPS - 1));
            step_in       = step_ff + STEP_W'(1);
            if (cmd.div_last && !status.more)
               state_in = status.neg ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.put_sign = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.put_digit = 1'b1;
               if (status.last_digit) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== src/integer_to_radix_symbols.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_symbols
// signed 32-bit integer to symbol bytes in a configurable radix
// ----------------------------------------------------------------------------
// usage
//   csr_*  : register writes, always ready; index 0 radix, 1 symbols 0..7,
//            2 symbols 8..15; write only while the block is idle
//   req_*  : one word per integer, taken when req_valid is high and
//            req_stall low; req_stall stays high until the last byte of
//            the current number is loaded into the output register
//   rsp_*  : one word per byte, most significant digit first, a minus
//            byte ahead of negative numbers, rsp_last on the final byte
//   sequence: accept and base check, then the divider resolves each
//            digit (8 quotient bits a cycle), then one byte per cycle
//            goes out while the receiver keeps rsp_stall low
//   one shared divider serves every digit, and no new number is taken
//            before the current one is through
//   an invalid base swallows the number after the check cycle
//   reset clears the csr registers to zero (invalid base) and drops rsp_valid
//   a stalled receiver holds the output word; the block waits in place
// ----------------------------------------------------------------------------
module integer_to_radix_symbols (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [i2rs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [i2rs_pkg::SYMS_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [i2rs_pkg::VALUE_W-1:0]   req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [i2rs_pkg::SYMBOL_W-1:0]  rsp_symbol,
   output logic                           rsp_last
);
   import i2rs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // register writes never wait
   assign csr_ready = 1'b1;

   // sequencer: owns the state and the divider step count
   i2rs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, divider, digit store and output word
   i2rs_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule

// ===== src/i2rs_chk.sv =====
// ----------------------------------------------------------------------------
// i2rs_chk
// port-level checks of the radix symbol converter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2rs_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [i2rs_pkg::SYMBOL_W-1:0]  rsp_symbol,
   input logic                           rsp_last
);

   // a held output word keeps its bytes
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_symbol) && $stable(rsp_last))

   // a taken number keeps the block busy for at least the check cycle
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall)

   // while bytes of a number are still to come, no new number is taken
   `ASSERT_IMPL(a_busy_mid_number, clock, reset, rsp_valid && !rsp_last, req_stall)

   // reset empties the output
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind integer_to_radix_symbols i2rs_chk u_chk (.*);
